// File: rtl/core/ate_pkg.sv
// Shared types and constants of the ANSI text terminal engine.
package ate_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_CSI    = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR,
        ST_SGR,
        ST_FILL,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_CLEAR,
        ACT_SGR,
        ACT_FILL
    } act_t;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic clr_step;
        logic sgr_step;
        logic fill_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        act_t act;
        logic clr_last;
        logic sgr_last;
        logic fill_last;
        logic out_free;
    } sts_t;

    localparam logic [1:0] CFG_ROWS = 2'd0;
    localparam logic [1:0] CFG_COLS = 2'd1;
    localparam logic [1:0] CFG_FG   = 2'd2;
    localparam logic [1:0] CFG_BG   = 2'd3;

    localparam logic [5:0] RESET_ROWS = 6'd24;
    localparam logic [7:0] RESET_COLS = 8'd80;
    localparam logic [2:0] RESET_FG   = 3'd7;
    localparam logic [2:0] RESET_BG   = 3'd0;

    localparam int CELL_W = 13;

    localparam logic [7:0] BYTE_ESC   = 8'd27;
    localparam logic [7:0] BYTE_LF    = 8'd10;
    localparam logic [7:0] BYTE_CR    = 8'd13;
    localparam logic [7:0] BYTE_BS    = 8'd8;
    localparam logic [7:0] BYTE_SPACE = 8'd32;
    localparam logic [7:0] BYTE_TILDE = 8'd126;
    localparam logic [7:0] BYTE_LBRK  = 8'h5B;
    localparam logic [7:0] BYTE_SEMI  = 8'h3B;
    localparam logic [7:0] BYTE_D0    = 8'h30;
    localparam logic [7:0] BYTE_D9    = 8'h39;
    localparam logic [7:0] BYTE_UA    = 8'h41;
    localparam logic [7:0] BYTE_UZ    = 8'h5A;
    localparam logic [7:0] BYTE_LA    = 8'h61;
    localparam logic [7:0] BYTE_LZ    = 8'h7A;

    localparam logic [7:0] FIN_RESET = 8'h63;
    localparam logic [7:0] FIN_SGR   = 8'h6D;
    localparam logic [7:0] FIN_CUP   = 8'h48;
    localparam logic [7:0] FIN_UP    = 8'h41;
    localparam logic [7:0] FIN_DOWN  = 8'h42;
    localparam logic [7:0] FIN_RIGHT = 8'h43;
    localparam logic [7:0] FIN_LEFT  = 8'h44;
    localparam logic [7:0] FIN_ED    = 8'h4A;
    localparam logic [7:0] FIN_EL    = 8'h4B;

    localparam logic [6:0]  CHAR_BLANK = 7'd32;
    localparam logic [15:0] PARAM_MAX  = 16'hFFFF;

    localparam logic [15:0] SGR_FG_LO  = 16'd30;
    localparam logic [15:0] SGR_FG_HI  = 16'd37;
    localparam logic [15:0] SGR_BG_LO  = 16'd40;
    localparam logic [15:0] SGR_BG_HI  = 16'd47;
    localparam logic [15:0] SGR_BFG_LO = 16'd90;
    localparam logic [15:0] SGR_BFG_HI = 16'd97;
    localparam logic [15:0] SGR_BBG_LO = 16'd100;
    localparam logic [15:0] SGR_BBG_HI = 16'd107;

endpackage

// File: rtl/core/ate_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ate_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: rtl/core/ate_ctrl.sv
// Sequencing state machine of the terminal engine.
module ate_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  ate_pkg::sts_t sts_i,
    output ate_pkg::cmd_t cmd_o
);
    ate_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ate_pkg::ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ate_pkg::ST_INIT: begin
                if (sts_i.clr_last) state_next = ate_pkg::ST_IDLE;
            end
            ate_pkg::ST_IDLE: begin
                if (s_axis_tvalid) state_next = ate_pkg::ST_EXEC;
            end
            ate_pkg::ST_EXEC: begin
                unique case (sts_i.act)
                    ate_pkg::ACT_CLEAR: state_next = ate_pkg::ST_CLEAR;
                    ate_pkg::ACT_SGR:   state_next = ate_pkg::ST_SGR;
                    ate_pkg::ACT_FILL:  state_next = ate_pkg::ST_FILL;
                    default:            state_next = ate_pkg::ST_DONE;
                endcase
            end
            ate_pkg::ST_CLEAR: begin
                if (sts_i.clr_last) state_next = ate_pkg::ST_DONE;
            end
            ate_pkg::ST_SGR: begin
                if (sts_i.sgr_last) state_next = ate_pkg::ST_DONE;
            end
            ate_pkg::ST_FILL: begin
                if (sts_i.fill_last) state_next = ate_pkg::ST_DONE;
            end
            ate_pkg::ST_DONE: begin
                if (sts_i.out_free) state_next = ate_pkg::ST_IDLE;
            end
            default: state_next = ate_pkg::ST_INIT;
        endcase
    end

    always_comb begin
        s_axis_tready   = (state_reg == ate_pkg::ST_IDLE);
        cmd_o.load_in   = (state_reg == ate_pkg::ST_IDLE) && s_axis_tvalid;
        cmd_o.exec      = (state_reg == ate_pkg::ST_EXEC);
        cmd_o.clr_step  = (state_reg == ate_pkg::ST_INIT) || (state_reg == ate_pkg::ST_CLEAR);
        cmd_o.sgr_step  = (state_reg == ate_pkg::ST_SGR);
        cmd_o.fill_step = (state_reg == ate_pkg::ST_FILL);
        cmd_o.out_load  = (state_reg == ate_pkg::ST_DONE) && sts_i.out_free;
    end
endmodule

// File: rtl/core/ate_dp.sv
// Datapath: parser registers, cursor, screen memory and output register.
module ate_dp #(
    parameter int MAX_ROWS   = 32,
    parameter int MAX_COLS   = 128,
    parameter int MAX_PARAMS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_addr,
    input  logic [7:0]    cfg_wdata,
    input  logic [23:0]   s_axis_tdata,
    input  logic [0:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [31:0]   m_axis_tdata,
    input  ate_pkg::cmd_t cmd_i,
    output ate_pkg::sts_t sts_o
);
    localparam int RW    = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int CCW   = $clog2(MAX_COLS + 1);
    localparam int PIW   = $clog2(MAX_PARAMS);
    localparam int PCW   = $clog2(MAX_PARAMS + 1);
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

    logic        in_cmd_reg;
    logic [7:0]  in_byte_reg;
    logic [4:0]  in_row_reg;
    logic [6:0]  in_col_reg;

    logic [5:0]  rows_cfg_reg, rows_cfg_next;
    logic [7:0]  cols_cfg_reg, cols_cfg_next;
    logic [2:0]  dfg_reg, dfg_next, dbg_reg, dbg_next;
    logic [RW-1:0] top_reg, top_next, crow_reg, crow_next;
    logic [CW-1:0] ccol_reg, ccol_next;
    logic [2:0]  fg_reg, fg_next, bg_reg, bg_next;
    ate_pkg::mode_t mode_reg, mode_next;
    logic [PCW-1:0] pcount_reg, pcount_next;
    logic [15:0] acc_reg, acc_next;
    logic        seen_reg, seen_next, pend_reg, pend_next;
    logic [15:0] param_reg [MAX_PARAMS];
    logic [15:0] param_next [MAX_PARAMS];
    logic [PIW-1:0] sgr_idx_reg, sgr_idx_next;
    logic [PCW-1:0] sgr_lim_reg, sgr_lim_next;
    logic [RW-1:0] fill_row_reg, fill_row_next, end_row_reg, end_row_next;
    logic [CW-1:0] fill_col_reg, fill_col_next, end_col_reg, end_col_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic        zero_reg, zero_next;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_data_reg, m_data_next;

    logic        ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [ate_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

    ate_ram #(.WIDTH(ate_pkg::CELL_W), .DEPTH(DEPTH)) u_screen (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    function automatic logic [RCW-1:0] clamp_rows(input logic [5:0] v);
        if (v == 6'd0) return RCW'(1);
        if (32'(v) > MAX_ROWS) return RCW'(MAX_ROWS);
        return RCW'(v);
    endfunction

    function automatic logic [CCW-1:0] clamp_cols(input logic [7:0] v);
        if (v == 8'd0) return CCW'(1);
        if (32'(v) > MAX_COLS) return CCW'(MAX_COLS);
        return CCW'(v);
    endfunction

    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] top,
                                               input logic [RW-1:0] row);
        logic [RW:0] s;
        s = {1'b0, top} + {1'b0, row};
        if (s >= (RW+1)'(MAX_ROWS)) s = s - (RW+1)'(MAX_ROWS);
        return s[RW-1:0];
    endfunction

    logic [RCW-1:0] ur, ur_w;
    logic [CCW-1:0] uc, uc_w;
    logic [RW-1:0]  row_last;
    logic [CW-1:0]  col_last;
    logic [ate_pkg::CELL_W-1:0] blank;
    logic [7:0]  b;
    logic        push_f, pfull, is_letter, is_digit, in_range;
    logic [PCW-1:0] ec;
    logic [15:0] p0, p1, n, v, md, sp;
    logic [16:0] n17, v17, rl17, cl17, cr17, cc17;
    logic [19:0] acc_mul;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] top,
                                                input logic [RW-1:0] row,
                                                input logic [CW-1:0] col);
        return AW'(phys_row(top, row)) * AW'(MAX_COLS) + AW'(col);
    endfunction

    always_comb begin
        ur       = clamp_rows(rows_cfg_reg);
        uc       = clamp_cols(cols_cfg_reg);
        row_last = RW'(ur - RCW'(1));
        col_last = CW'(uc - CCW'(1));
        blank    = {bg_reg, fg_reg, ate_pkg::CHAR_BLANK};
        b        = in_byte_reg;
        push_f   = pend_reg || seen_reg;
        pfull    = (pcount_reg >= PCW'(MAX_PARAMS));
        ec       = (push_f && !pfull) ? pcount_reg + PCW'(1) : pcount_reg;
        p0       = (pcount_reg == PCW'(0) && push_f) ? acc_reg : param_reg[0];
        p1       = (pcount_reg == PCW'(1) && push_f) ? acc_reg : param_reg[1];
        n        = (ec != PCW'(0)) ? p0 : 16'd1;
        v        = (ec > PCW'(1)) ? p1 : 16'd1;
        md       = (ec != PCW'(0)) ? p0 : 16'd0;
        n17      = {1'b0, n};
        v17      = {1'b0, v};
        rl17     = 17'(row_last);
        cl17     = 17'(col_last);
        cr17     = 17'(crow_reg);
        cc17     = 17'(ccol_reg);
        acc_mul  = {acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + 20'(b - ate_pkg::BYTE_D0);
        is_letter = (b >= ate_pkg::BYTE_UA && b <= ate_pkg::BYTE_UZ) ||
                    (b >= ate_pkg::BYTE_LA && b <= ate_pkg::BYTE_LZ);
        is_digit  = (b >= ate_pkg::BYTE_D0 && b <= ate_pkg::BYTE_D9);
        in_range  = (in_row_reg < ur) && (in_col_reg < uc);
        sp        = param_reg[sgr_idx_reg];
        ur_w      = clamp_rows(cfg_wdata[5:0]);
        uc_w      = clamp_cols(cfg_wdata);
    end

    always_comb begin
        rows_cfg_next = rows_cfg_reg;
        cols_cfg_next = cols_cfg_reg;
        dfg_next      = dfg_reg;
        dbg_next      = dbg_reg;
        top_next      = top_reg;
        crow_next     = crow_reg;
        ccol_next     = ccol_reg;
        fg_next       = fg_reg;
        bg_next       = bg_reg;
        mode_next     = mode_reg;
        pcount_next   = pcount_reg;
        acc_next      = acc_reg;
        seen_next     = seen_reg;
        pend_next     = pend_reg;
        param_next    = param_reg;
        sgr_idx_next  = sgr_idx_reg;
        sgr_lim_next  = sgr_lim_reg;
        fill_row_next = fill_row_reg;
        fill_col_next = fill_col_reg;
        end_row_next  = end_row_reg;
        end_col_next  = end_col_reg;
        clr_cnt_next  = clr_cnt_reg;
        zero_next     = zero_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        ram_we        = 1'b0;
        ram_waddr     = cell_addr(top_reg, crow_reg, ccol_reg);
        ram_wdata     = blank;
        ram_re        = 1'b0;
        ram_raddr     = cell_addr(top_reg, RW'(in_row_reg), CW'(in_col_reg));
        sts_o.act     = ate_pkg::ACT_NONE;

        if (cmd_i.exec) begin
            if (in_cmd_reg) begin
                ram_re    = 1'b1;
                zero_next = !in_range;
            end else begin
                zero_next = 1'b1;
                unique case (mode_reg)
                    ate_pkg::MODE_ESCAPE: begin
                        if (b == ate_pkg::BYTE_LBRK) begin
                            mode_next   = ate_pkg::MODE_CSI;
                            pcount_next = '0;
                            acc_next    = '0;
                            seen_next   = 1'b0;
                            pend_next   = 1'b0;
                        end else begin
                            mode_next = ate_pkg::MODE_NORMAL;
                            if (b == ate_pkg::FIN_RESET) sts_o.act = ate_pkg::ACT_CLEAR;
                        end
                    end
                    ate_pkg::MODE_CSI: begin
                        if (is_letter) begin
                            mode_next   = ate_pkg::MODE_NORMAL;
                            pcount_next = '0;
                            acc_next    = '0;
                            seen_next   = 1'b0;
                            pend_next   = 1'b0;
                            if (push_f && !pfull) param_next[pcount_reg[PIW-1:0]] = acc_reg;
                            unique case (b)
                                ate_pkg::FIN_RESET: sts_o.act = ate_pkg::ACT_CLEAR;
                                ate_pkg::FIN_SGR: begin
                                    if (ec == PCW'(0)) begin
                                        fg_next = dfg_reg;
                                        bg_next = dbg_reg;
                                    end else begin
                                        sgr_lim_next = ec;
                                        sgr_idx_next = '0;
                                        sts_o.act    = ate_pkg::ACT_SGR;
                                    end
                                end
                                ate_pkg::FIN_CUP: begin
                                    if (n == 16'd0) crow_next = '0;
                                    else crow_next = RW'((n17 - 17'd1) > rl17 ? rl17
                                                                         : n17 - 17'd1);
                                    if (v == 16'd0) ccol_next = '0;
                                    else ccol_next = CW'((v17 - 17'd1) > cl17 ? cl17
                                                                         : v17 - 17'd1);
                                end
                                ate_pkg::FIN_UP:
                                    crow_next = (cr17 < n17) ? '0 : RW'(cr17 - n17);
                                ate_pkg::FIN_DOWN:
                                    crow_next = RW'((cr17 + n17) > rl17 ? rl17 : cr17 + n17);
                                ate_pkg::FIN_RIGHT:
                                    ccol_next = CW'((cc17 + n17) > cl17 ? cl17 : cc17 + n17);
                                ate_pkg::FIN_LEFT:
                                    ccol_next = (cc17 < n17) ? '0 : CW'(cc17 - n17);
                                ate_pkg::FIN_ED: begin
                                    if (md == 16'd0 || md == 16'd2) begin
                                        fill_row_next = crow_reg;
                                        fill_col_next = ccol_reg;
                                        end_row_next  = row_last;
                                        end_col_next  = col_last;
                                        sts_o.act     = ate_pkg::ACT_FILL;
                                    end
                                end
                                ate_pkg::FIN_EL: begin
                                    fill_row_next = crow_reg;
                                    end_row_next  = crow_reg;
                                    fill_col_next = (md == 16'd0) ? ccol_reg : '0;
                                    end_col_next  = (md == 16'd1) ? ccol_reg : col_last;
                                    if (md <= 16'd2) sts_o.act = ate_pkg::ACT_FILL;
                                end
                                default: ;
                            endcase
                        end else if (is_digit) begin
                            acc_next  = (acc_mul > 20'(ate_pkg::PARAM_MAX)) ? ate_pkg::PARAM_MAX
                                                                          : acc_mul[15:0];
                            seen_next = 1'b1;
                            pend_next = 1'b0;
                        end else if (b == ate_pkg::BYTE_SEMI) begin
                            if (!pfull) begin
                                param_next[pcount_reg[PIW-1:0]] = acc_reg;
                                pcount_next = pcount_reg + PCW'(1);
                            end
                            acc_next  = '0;
                            seen_next = 1'b0;
                            pend_next = 1'b0;
                        end else begin
                            pend_next = 1'b1;
                        end
                    end
                    default: begin
                        logic line_down;
                        line_down = 1'b0;
                        if (b == ate_pkg::BYTE_ESC) begin
                            mode_next   = ate_pkg::MODE_ESCAPE;
                            pcount_next = '0;
                            acc_next    = '0;
                            seen_next   = 1'b0;
                            pend_next   = 1'b0;
                        end else if (b == ate_pkg::BYTE_LF) begin
                            ccol_next = '0;
                            line_down = 1'b1;
                        end else if (b == ate_pkg::BYTE_CR) begin
                            ccol_next = '0;
                        end else if (b == ate_pkg::BYTE_BS) begin
                            if (ccol_reg != '0) begin
                                ccol_next = ccol_reg - CW'(1);
                                ram_we    = 1'b1;
                                ram_waddr = cell_addr(top_reg, crow_reg, ccol_reg - CW'(1));
                            end
                        end else if (b >= ate_pkg::BYTE_SPACE && b <= ate_pkg::BYTE_TILDE) begin
                            ram_we    = 1'b1;
                            ram_wdata = {bg_reg, fg_reg, b[6:0]};
                            if ((CCW+1)'(ccol_reg) + (CCW+1)'(1) >= (CCW+1)'(uc)) begin
                                ccol_next = '0;
                                line_down = 1'b1;
                            end else begin
                                ccol_next = ccol_reg + CW'(1);
                            end
                        end
                        if (line_down) begin
                            if ((RCW+1)'(crow_reg) + (RCW+1)'(1) >= (RCW+1)'(ur)) begin
                                top_next      = phys_row(top_reg, RW'(1));
                                crow_next     = row_last;
                                fill_row_next = row_last;
                                fill_col_next = '0;
                                end_row_next  = row_last;
                                end_col_next  = col_last;
                                sts_o.act     = ate_pkg::ACT_FILL;
                            end else begin
                                crow_next = crow_reg + RW'(1);
                            end
                        end
                    end
                endcase
                if (sts_o.act == ate_pkg::ACT_CLEAR) begin
                    fg_next      = dfg_reg;
                    bg_next      = dbg_reg;
                    crow_next    = '0;
                    ccol_next    = '0;
                    top_next     = '0;
                    clr_cnt_next = '0;
                end
            end
        end

        sts_o.clr_last = (clr_cnt_reg == AW'(DEPTH - 1));
        if (cmd_i.clr_step) begin
            ram_we       = 1'b1;
            ram_waddr    = clr_cnt_reg;
            clr_cnt_next = clr_cnt_reg + AW'(1);
        end

        sts_o.sgr_last = (PCW'(sgr_idx_reg) == sgr_lim_reg - PCW'(1));
        if (cmd_i.sgr_step) begin
            sgr_idx_next = sgr_idx_reg + PIW'(1);
            if (sp == 16'd0) begin
                fg_next = dfg_reg;
                bg_next = dbg_reg;
            end else if (sp >= ate_pkg::SGR_FG_LO && sp <= ate_pkg::SGR_FG_HI) begin
                fg_next = 3'(sp - ate_pkg::SGR_FG_LO);
            end else if (sp >= ate_pkg::SGR_BG_LO && sp <= ate_pkg::SGR_BG_HI) begin
                bg_next = 3'(sp - ate_pkg::SGR_BG_LO);
            end else if (sp >= ate_pkg::SGR_BFG_LO && sp <= ate_pkg::SGR_BFG_HI) begin
                fg_next = 3'(sp - ate_pkg::SGR_BFG_LO);
            end else if (sp >= ate_pkg::SGR_BBG_LO && sp <= ate_pkg::SGR_BBG_HI) begin
                bg_next = 3'(sp - ate_pkg::SGR_BBG_LO);
            end
        end

        sts_o.fill_last = (fill_row_reg == end_row_reg) && (fill_col_reg == end_col_reg);
        if (cmd_i.fill_step) begin
            ram_we    = 1'b1;
            ram_waddr = cell_addr(top_reg, fill_row_reg, fill_col_reg);
            if (fill_col_reg == col_last) begin
                fill_col_next = '0;
                fill_row_next = fill_row_reg + RW'(1);
            end else begin
                fill_col_next = fill_col_reg + CW'(1);
            end
        end

        sts_o.out_free = !m_valid_reg || m_axis_tready;
        if (m_valid_reg && m_axis_tready) m_valid_next = 1'b0;
        if (cmd_i.out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = {5'd0, mode_reg, 7'(ccol_reg), 5'(crow_reg),
                            zero_reg ? 13'd0 : ram_rdata};
        end

        if (cfg_wr_en) begin
            unique case (cfg_addr)
                ate_pkg::CFG_ROWS: begin
                    rows_cfg_next = cfg_wdata[5:0];
                    if ((RCW+1)'(crow_reg) >= (RCW+1)'(ur_w)) crow_next = RW'(ur_w - RCW'(1));
                end
                ate_pkg::CFG_COLS: begin
                    cols_cfg_next = cfg_wdata;
                    if ((CCW+1)'(ccol_reg) >= (CCW+1)'(uc_w)) ccol_next = CW'(uc_w - CCW'(1));
                end
                ate_pkg::CFG_FG: dfg_next = cfg_wdata[2:0];
                ate_pkg::CFG_BG: dbg_next = cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg <= ate_pkg::RESET_ROWS;
            cols_cfg_reg <= ate_pkg::RESET_COLS;
            dfg_reg      <= ate_pkg::RESET_FG;
            dbg_reg      <= ate_pkg::RESET_BG;
            top_reg      <= '0;
            crow_reg     <= '0;
            ccol_reg     <= '0;
            fg_reg       <= ate_pkg::RESET_FG;
            bg_reg       <= ate_pkg::RESET_BG;
            mode_reg     <= ate_pkg::MODE_NORMAL;
            pcount_reg   <= '0;
            acc_reg      <= '0;
            seen_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            sgr_idx_reg  <= '0;
            sgr_lim_reg  <= '0;
            clr_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            rows_cfg_reg <= rows_cfg_next;
            cols_cfg_reg <= cols_cfg_next;
            dfg_reg      <= dfg_next;
            dbg_reg      <= dbg_next;
            top_reg      <= top_next;
            crow_reg     <= crow_next;
            ccol_reg     <= ccol_next;
            fg_reg       <= fg_next;
            bg_reg       <= bg_next;
            mode_reg     <= mode_next;
            pcount_reg   <= pcount_next;
            acc_reg      <= acc_next;
            seen_reg     <= seen_next;
            pend_reg     <= pend_next;
            sgr_idx_reg  <= sgr_idx_next;
            sgr_lim_reg  <= sgr_lim_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.load_in) begin
            in_cmd_reg  <= s_axis_tuser[0];
            in_byte_reg <= s_axis_tdata[7:0];
            in_row_reg  <= s_axis_tdata[12:8];
            in_col_reg  <= s_axis_tdata[19:13];
        end
        param_reg    <= param_next;
        fill_row_reg <= fill_row_next;
        fill_col_reg <= fill_col_next;
        end_row_reg  <= end_row_next;
        end_col_reg  <= end_col_next;
        zero_reg     <= zero_next;
        m_data_reg   <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
endmodule

// File: rtl/core/ansi_text_terminal_engine_core.sv
// Top level of the ANSI text terminal engine: controller, datapath and checks.
//
// The host sends items on the s_axis channel: tuser[0] selects feeding a byte (0)
// or reading one screen cell (1). Every item gives exactly one result item on
// m_axis: the cell read (zero for a byte or an off-screen read), the cursor and
// the parser mode after the item.
// An ordinary byte or a read is accepted, executed (screen memory write or read)
// and then loaded into the result register.
// Erasing, scrolling and SGR lists then step through cells or parameters, one per
// cycle: a scroll blanks the visible columns of the last row, ED/EL the cells erased,
// and a full reset (ESC c, CSI ... c) sweeps all MAX_ROWS*MAX_COLS cells.
// After aresetn the same sweep runs before the first item is accepted;
// configuration writes are taken throughout.
// A stalled receiver holds the result in the output register; the next item is
// still accepted and worked on, and waits only at the final load.
// Configuration: cfg_wr_en with cfg_addr 0 rows, 1 columns, 2 default fg, 3
// default bg; write only while no item is in flight.
module ansi_text_terminal_engine_core #(
    parameter int MAX_ROWS   = 32,
    parameter int MAX_COLS   = 128,
    parameter int MAX_PARAMS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // data_byte[7:0], read_row[12:8], read_col[19:13]
    input  logic [0:0]  s_axis_tuser,  // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // cell_char[6:0], cell_fg[9:7], cell_bg[12:10], cursor_row[17:13],
    // cursor_col[24:18], parser_mode[26:25]
    output logic [31:0] m_axis_tdata
);
    ate_pkg::cmd_t cmd;
    ate_pkg::sts_t sts;

    ate_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts_i         (sts),
        .cmd_o         (cmd)
    );

    ate_dp #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .MAX_PARAMS (MAX_PARAMS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cmd_i         (cmd),
        .sts_o         (sts)
    );

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while another is in work");

    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_step || cmd.fill_step || cmd.sgr_step |-> !s_axis_tready)
        else $error("input ready during a sweep");

    a_load_into_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !m_axis_tvalid || m_axis_tready)
        else $error("result loaded over a pending one");

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_axis_tvalid)
        else $error("loaded result not presented");
endmodule

// File: tb/testbench.sv
// Testbench of the ANSI text terminal engine: random byte streams and cell reads checked against a predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NR = 32;
    localparam int NC = 128;
    localparam int NP = 16;
    localparam int WATCHDOG = 40000;

    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] ccol;
        logic [4:0] crow;
        logic [2:0] bg;
        logic [2:0] fg;
        logic [6:0] ch;
    } screen_resp_t;

    class terminal_scoreboard;
        logic [12:0] cells [NR*NC];
        int top, crow, ccol, afg, abg;
        ate_pkg::mode_t mode;
        int pv [NP];
        int pcnt, acc;
        bit dseen, pend;
        int rows_cfg, cols_cfg, dfg, dbg;
        screen_resp_t pending_resp [$];
        int errors;

        function int nrows();
            return rows_cfg < 1 ? 1 : (rows_cfg > NR ? NR : rows_cfg);
        endfunction
        function int ncols();
            return cols_cfg < 1 ? 1 : (cols_cfg > NC ? NC : cols_cfg);
        endfunction
        function int idx(int r, int c);
            return ((top + r) % NR) * NC + (c % NC);
        endfunction
        function void blank(int r, int c);
            cells[idx(r, c)] = {abg[2:0], afg[2:0], ate_pkg::CHAR_BLANK};
        endfunction
        function void wipe_all();
            afg = dfg; abg = dbg; crow = 0; ccol = 0; top = 0;
            foreach (cells[i]) cells[i] = {abg[2:0], afg[2:0], ate_pkg::CHAR_BLANK};
        endfunction
        function void clear_params();
            pcnt = 0; acc = 0; dseen = 0; pend = 0;
        endfunction
        function void push_param(int v);
            if (pcnt < NP) begin
                pv[pcnt] = v; pcnt++;
            end
            acc = 0; dseen = 0; pend = 0;
        endfunction
        function void init();
            rows_cfg = ate_pkg::RESET_ROWS; cols_cfg = ate_pkg::RESET_COLS;
            dfg = ate_pkg::RESET_FG; dbg = ate_pkg::RESET_BG;
            foreach (pv[i]) pv[i] = 0;
            mode = ate_pkg::MODE_NORMAL;
            clear_params();
            wipe_all();
            errors = 0;
        endfunction
        function void line_down();
            crow++;
            if (crow >= nrows()) begin
                top = (top + 1) % NR;
                for (int c = 0; c < ncols(); c++) blank(nrows() - 1, c);
                crow = nrows() - 1;
            end
        endfunction
        function void sgr(int p);
            if (p == 0) begin afg = dfg; abg = dbg; end
            else if (p >= ate_pkg::SGR_FG_LO && p <= ate_pkg::SGR_FG_HI)
                afg = p - ate_pkg::SGR_FG_LO;
            else if (p >= ate_pkg::SGR_BG_LO && p <= ate_pkg::SGR_BG_HI)
                abg = p - ate_pkg::SGR_BG_LO;
            else if (p >= ate_pkg::SGR_BFG_LO && p <= ate_pkg::SGR_BFG_HI)
                afg = p - ate_pkg::SGR_BFG_LO;
            else if (p >= ate_pkg::SGR_BBG_LO && p <= ate_pkg::SGR_BBG_HI)
                abg = p - ate_pkg::SGR_BBG_LO;
        endfunction
        function void final_byte(logic [7:0] f);
            int rows, cols, cr, cc, n, md, r, c;
            rows = nrows(); cols = ncols(); cr = crow; cc = ccol;
            if (pend) push_param(dseen ? acc : 0);
            else if (dseen) push_param(acc);
            n = pcnt > 0 ? pv[0] : 1;
            md = pcnt > 0 ? pv[0] : 0;
            case (f)
                ate_pkg::FIN_RESET: begin wipe_all(); return; end
                ate_pkg::FIN_SGR: begin
                    if (pcnt == 0) sgr(0);
                    for (int i = 0; i < pcnt; i++) sgr(pv[i]);
                    return;
                end
                ate_pkg::FIN_CUP: begin
                    r = n - 1; c = (pcnt > 1 ? pv[1] : 1) - 1;
                    cr = r < 0 ? 0 : (r > rows - 1 ? rows - 1 : r);
                    cc = c < 0 ? 0 : (c > cols - 1 ? cols - 1 : c);
                end
                ate_pkg::FIN_UP: cr = cr - n < 0 ? 0 : cr - n;
                ate_pkg::FIN_DOWN: cr = cr + n > rows - 1 ? rows - 1 : cr + n;
                ate_pkg::FIN_RIGHT: cc = cc + n > cols - 1 ? cols - 1 : cc + n;
                ate_pkg::FIN_LEFT: cc = cc - n < 0 ? 0 : cc - n;
                ate_pkg::FIN_ED: begin
                    if (md == 0 || md == 2)
                        for (r = cr; r < rows; r++)
                            for (c = (r == cr ? cc : 0); c < cols; c++) blank(r, c);
                    return;
                end
                ate_pkg::FIN_EL: begin
                    if (md == 0) for (c = cc; c < cols; c++) blank(cr, c);
                    else if (md == 1) for (c = 0; c <= cc; c++) blank(cr, c);
                    else if (md == 2) for (c = 0; c < cols; c++) blank(cr, c);
                    return;
                end
                default: return;
            endcase
            crow = cr; ccol = cc;
        endfunction
        function void feed(logic [7:0] b);
            if (mode == ate_pkg::MODE_ESCAPE) begin
                if (b == ate_pkg::BYTE_LBRK) begin
                    mode = ate_pkg::MODE_CSI; clear_params();
                end else begin
                    if (b == ate_pkg::FIN_RESET) wipe_all();
                    mode = ate_pkg::MODE_NORMAL;
                end
            end else if (mode == ate_pkg::MODE_CSI) begin
                if ((b >= ate_pkg::BYTE_UA && b <= ate_pkg::BYTE_UZ) ||
                    (b >= ate_pkg::BYTE_LA && b <= ate_pkg::BYTE_LZ)) begin
                    final_byte(b);
                    mode = ate_pkg::MODE_NORMAL;
                    clear_params();
                end else if (b >= ate_pkg::BYTE_D0 && b <= ate_pkg::BYTE_D9) begin
                    acc = acc * 10 + int'(b - ate_pkg::BYTE_D0);
                    if (acc > ate_pkg::PARAM_MAX) acc = ate_pkg::PARAM_MAX;
                    dseen = 1; pend = 0;
                end else if (b == ate_pkg::BYTE_SEMI) push_param(dseen ? acc : 0);
                else pend = 1;
            end else if (b == ate_pkg::BYTE_ESC) begin
                mode = ate_pkg::MODE_ESCAPE; clear_params();
            end else if (b == ate_pkg::BYTE_LF) begin
                ccol = 0; line_down();
            end else if (b == ate_pkg::BYTE_CR) ccol = 0;
            else if (b == ate_pkg::BYTE_BS) begin
                if (ccol > 0) begin ccol--; blank(crow, ccol); end
            end else if (b >= ate_pkg::BYTE_SPACE && b <= ate_pkg::BYTE_TILDE) begin
                cells[idx(crow, ccol)] = {abg[2:0], afg[2:0], b[6:0]};
                ccol++;
                if (ccol >= ncols()) begin ccol = 0; line_down(); end
            end
        endfunction
        function void write_reg(logic [1:0] a, logic [7:0] v);
            case (a)
                ate_pkg::CFG_ROWS: rows_cfg = v[5:0];
                ate_pkg::CFG_COLS: cols_cfg = v;
                ate_pkg::CFG_FG: begin dfg = v[2:0]; return; end
                ate_pkg::CFG_BG: begin dbg = v[2:0]; return; end
            endcase
            if (crow >= nrows()) crow = nrows() - 1;
            if (ccol >= ncols()) ccol = ncols() - 1;
        endfunction
        function void note_input(logic cmd, logic [23:0] d);
            screen_resp_t e;
            logic [12:0] cl;
            e = '0;
            if (!cmd) feed(d[7:0]);
            else if (d[12:8] < nrows() && d[19:13] < ncols()) begin
                cl = cells[idx(d[12:8], d[19:13])];
                e.ch = cl[6:0]; e.fg = cl[9:7]; e.bg = cl[12:10];
            end
            e.crow = 5'(crow); e.ccol = 7'(ccol); e.mode = mode;
            pending_resp = {pending_resp, e};
        endfunction
        function void report(string f, int e, int a);
            $display("%0t: %s expected %0d actual %0d", $time, f, e, a);
            errors++;
        endfunction
        function void check_result(logic [31:0] d);
            screen_resp_t e, a;
            a = d[26:0];
            if (pending_resp.size() == 0) begin
                $display("%0t: unexpected result %h", $time, d);
                errors++;
                return;
            end
            e = pending_resp.pop_front();
            if (a.ch !== e.ch) report("cell_char", e.ch, a.ch);
            if (a.fg !== e.fg) report("cell_fg", e.fg, a.fg);
            if (a.bg !== e.bg) report("cell_bg", e.bg, a.bg);
            if (a.crow !== e.crow) report("cursor_row", e.crow, a.crow);
            if (a.ccol !== e.ccol) report("cursor_col", e.ccol, a.ccol);
            if (a.mode !== e.mode) report("parser_mode", e.mode, a.mode);
        endfunction
    endclass

    logic aclk = 0, aresetn = 0;
    logic cfg_wr_en = 0;
    logic [1:0] cfg_addr = '0;
    logic [7:0] cfg_wdata = '0;
    logic s_axis_tvalid = 0, s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [0:0] s_axis_tuser = '0;
    logic m_axis_tvalid, m_axis_tready = 0;
    logic [31:0] m_axis_tdata;

    terminal_scoreboard sb = new();
    bit calm = 0, hold_off = 0;
    int idle_cnt = 0;

    ansi_text_terminal_engine_core i_dut (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tuser[0], s_axis_tdata);
        if (aresetn && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        if (aresetn && ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > WATCHDOG) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : sink
        int n;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_axis_tready <= 0;
                repeat (300) @(posedge aclk);
                hold_off = 0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 0;
                n = $urandom_range(1, 5);
                repeat (n - 1) @(posedge aclk);
            end else
                m_axis_tready <= 1;
        end
    end

    task automatic send(logic cmd, logic [23:0] d);
        int n;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 0;
            n = $urandom_range(1, 5);
            repeat (n) @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= d;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic put_byte(logic [7:0] b);
        send(1'b0, {16'($urandom_range(0, 65535)), b});
    endtask

    task automatic read_cell(int r, int c);
        send(1'b1, {4'($urandom), 7'(c), 5'(r), 8'($urandom)});
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending_resp.size() != 0) @(posedge aclk);
        repeat (5000) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] a, logic [7:0] v);
        cfg_wr_en <= 1; cfg_addr <= a; cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 0;
        sb.write_reg(a, v);
        @(posedge aclk);
    endtask

    task automatic random_item();
        int k;
        string fins;
        fins = "mHABCDJKcxq";
        k = $urandom_range(0, 99);
        if (k < 25) read_cell($urandom_range(0, 31), $urandom_range(0, 127));
        else if (k < 55) put_byte(8'($urandom_range(32, 126)));
        else if (k < 62) put_byte(8'($urandom_range(0, 255)));
        else if (k < 66) put_byte(k[0] ? ate_pkg::BYTE_LF : (k[1] ? ate_pkg::BYTE_CR
                                                                  : ate_pkg::BYTE_BS));
        else if (k < 98) begin
            put_byte(ate_pkg::BYTE_ESC);
            put_byte(ate_pkg::BYTE_LBRK);
            for (int p = $urandom_range(0, 3); p > 0; p--) begin
                put_text($sformatf("%0d", $urandom_range(0, 3) == 0 ?
                         $urandom_range(0, 120) : $urandom_range(0, 9)));
                if ($urandom_range(0, 9) == 0) put_byte("?");
                if (p > 1) put_byte(ate_pkg::BYTE_SEMI);
            end
            k = $urandom_range(0, 60) == 0 ? 8 : $urandom_range(0, 7);
            put_byte(fins[k]);
        end else begin
            put_byte(ate_pkg::BYTE_ESC);
            put_byte($urandom_range(0, 20) == 0 ? ate_pkg::FIN_RESET
                                                : 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        sb.init();
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        put_text("A~ ");
        put_byte(8'hFF); put_byte(8'h7F); put_byte(8'h00);
        read_cell(0, 0); read_cell(0, 1); read_cell(31, 127);
        put_text("\033[31;104m"); put_text("Z\033[m"); read_cell(0, 3);
        put_text("\033[99999;5H"); put_text("\033[2A\033[B\033[0C\033[3D");
        put_text("\033[?K\033[1K\033[2J\033x");
        put_byte(ate_pkg::BYTE_LF); put_byte(ate_pkg::BYTE_BS); put_byte(ate_pkg::BYTE_CR);
        put_text("\033c");
        drain();
        write_reg(ate_pkg::CFG_ROWS, 8'd1); write_reg(ate_pkg::CFG_COLS, 8'd1);
        write_reg(ate_pkg::CFG_FG, 8'd0); write_reg(ate_pkg::CFG_BG, 8'd7);
        for (int i = 0; i < 25; i++) random_item();
        drain();
        write_reg(ate_pkg::CFG_ROWS, 8'd0); write_reg(ate_pkg::CFG_COLS, 8'd0);
        for (int i = 0; i < 15; i++) random_item();
        drain();
        write_reg(ate_pkg::CFG_ROWS, 8'd63); write_reg(ate_pkg::CFG_COLS, 8'd255);
        write_reg(ate_pkg::CFG_FG, 8'd5); write_reg(ate_pkg::CFG_BG, 8'd2);
        hold_off = 1;
        for (int i = 0; i < 150; i++) random_item();
        drain();
        write_reg(ate_pkg::CFG_ROWS, 8'd4); write_reg(ate_pkg::CFG_COLS, 8'd10);
        for (int i = 0; i < 180; i++) random_item();
        drain();
        write_reg(ate_pkg::CFG_ROWS, 8'($urandom_range(1, 32)));
        write_reg(ate_pkg::CFG_COLS, 8'($urandom_range(1, 128)));
        write_reg(ate_pkg::CFG_FG, 8'($urandom_range(0, 7)));
        write_reg(ate_pkg::CFG_BG, 8'($urandom_range(0, 7)));
        for (int i = 0; i < 150; i++) random_item();
        calm = 1;
        for (int i = 0; i < 60; i++) random_item();
        drain();
        if (sb.errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
